[hw/rtl/wsfr_pkg.sv]
// Shared types and constants for the WebSocket frame receiver.
package wsfr_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned OPCODE_W    = 4;
   localparam int unsigned LENGTH_W    = 64;
   localparam int unsigned KEY_W       = 32;
   localparam int unsigned RSP_DATA_W  = 16;

   localparam logic [OPCODE_W-1:0] OPCODE_CLOSE = 4'h8;
   localparam logic [6:0]          LEN7_EXT16   = 7'd126;
   localparam logic [6:0]          LEN7_EXT64   = 7'd127;
   localparam logic [2:0]          EXT16_BYTES  = 3'd1;
   localparam logic [2:0]          EXT64_BYTES  = 3'd7;
   localparam logic [2:0]          KEY_BYTES    = 3'd3;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_CLOSE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic                last;
      logic [OPCODE_W-1:0] frame_opcode;
   } result_type;

endpackage

[hw/rtl/wsfr_parser.sv]
// Frame header parser, length counter and payload unmasking.
module wsfr_parser
   import wsfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              link_closed,
   output result_type        res
);

   phase_type             phase_ff, phase_in;
   logic [OPCODE_W-1:0]   opcode_ff, opcode_in;
   logic                  masked_ff, masked_in;
   logic [LENGTH_W-1:0]   rem_ff, rem_in;
   logic [2:0]            hbc_ff, hbc_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [1:0]            midx_ff, midx_in;

   logic [6:0]            len7;
   logic                  is_ext;
   logic [LENGTH_W-1:0]   ext_len;
   logic [KEY_W-1:0]      key_shift;
   logic [LENGTH_W-1:0]   rem_dec;
   logic [1:0]            key_sel;
   logic [BYTE_W-1:0]     key_byte;

   assign len7      = rx_byte[6:0];
   assign is_ext    = (len7 == LEN7_EXT16) || (len7 == LEN7_EXT64);
   assign ext_len   = {rem_ff[LENGTH_W-BYTE_W-1:0], rx_byte};
   assign key_shift = {key_ff[KEY_W-BYTE_W-1:0], rx_byte};
   assign rem_dec   = rem_ff - LENGTH_W'(1);
   assign key_sel   = 2'd3 - midx_ff;
   assign key_byte  = key_ff[{key_sel, 3'b000} +: BYTE_W];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (link_closed) begin
            phase_in = PH_HDR0;
         end else begin
            case (phase_ff)
               PH_HDR1: begin
                  if (opcode_ff == OPCODE_CLOSE)  phase_in = PH_HDR0;
                  else if (is_ext)                phase_in = PH_EXTLEN;
                  else if (rx_byte[7])            phase_in = PH_KEY;
                  else if (len7 == 7'd0)          phase_in = PH_HDR0;
                  else                            phase_in = PH_PAYLOAD;
               end
               PH_EXTLEN: begin
                  if (hbc_ff == 3'd0) begin
                     if (masked_ff)               phase_in = PH_KEY;
                     else if (ext_len == '0)      phase_in = PH_HDR0;
                     else                         phase_in = PH_PAYLOAD;
                  end
               end
               PH_KEY: begin
                  if (hbc_ff == 3'd0) begin
                     if (rem_ff == '0)            phase_in = PH_HDR0;
                     else                         phase_in = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  if (rem_dec == '0)              phase_in = PH_HDR0;
               end
               default: begin
                  phase_in = PH_HDR1;
               end
            endcase
         end
      end
   end

   // datapath and result
   always_comb begin
      opcode_in        = opcode_ff;
      masked_in        = masked_ff;
      rem_in           = rem_ff;
      hbc_in           = hbc_ff;
      key_in           = key_ff;
      midx_in          = midx_ff;
      res.valid        = 1'b0;
      res.kind         = KIND_BYTE;
      res.payload_byte = '0;
      res.last         = 1'b1;
      res.frame_opcode = opcode_ff;
      if (step) begin
         if (link_closed) begin
            opcode_in        = '0;
            masked_in        = 1'b0;
            rem_in           = '0;
            hbc_in           = '0;
            key_in           = '0;
            midx_in          = '0;
            res.valid        = 1'b1;
            res.kind         = KIND_CLOSE;
            res.frame_opcode = '0;
         end else begin
            case (phase_ff)
               PH_HDR1: begin
                  if (opcode_ff == OPCODE_CLOSE) begin
                     res.valid = 1'b1;
                     res.kind  = KIND_CLOSE;
                  end else begin
                     masked_in = rx_byte[7];
                     if (is_ext) begin
                        rem_in = '0;
                        hbc_in = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                     end else begin
                        rem_in = LENGTH_W'(len7);
                        key_in = '0;
                        if (rx_byte[7]) begin
                           hbc_in = KEY_BYTES;
                        end else if (len7 == 7'd0) begin
                           res.valid = 1'b1;
                           res.kind  = KIND_EMPTY;
                        end else begin
                           midx_in = '0;
                        end
                     end
                  end
               end
               PH_EXTLEN: begin
                  rem_in = ext_len;
                  if (hbc_ff == 3'd0) begin
                     key_in = '0;
                     if (masked_ff) begin
                        hbc_in = KEY_BYTES;
                     end else if (ext_len == '0) begin
                        res.valid = 1'b1;
                        res.kind  = KIND_EMPTY;
                     end else begin
                        midx_in = '0;
                     end
                  end else begin
                     hbc_in = hbc_ff - 3'd1;
                  end
               end
               PH_KEY: begin
                  key_in = key_shift;
                  if (hbc_ff == 3'd0) begin
                     if (rem_ff == '0) begin
                        res.valid = 1'b1;
                        res.kind  = KIND_EMPTY;
                     end else begin
                        midx_in = '0;
                     end
                  end else begin
                     hbc_in = hbc_ff - 3'd1;
                  end
               end
               PH_PAYLOAD: begin
                  rem_in           = rem_dec;
                  midx_in          = midx_ff + 2'd1;
                  res.valid        = 1'b1;
                  res.kind         = KIND_BYTE;
                  res.payload_byte = rx_byte ^ key_byte;
                  res.last         = (rem_dec == '0);
               end
               default: begin
                  opcode_in = rx_byte[OPCODE_W-1:0];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= '0;
         masked_ff <= 1'b0;
         rem_ff    <= '0;
         hbc_ff    <= '0;
         key_ff    <= '0;
         midx_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         rem_ff    <= rem_in;
         hbc_ff    <= hbc_in;
         key_ff    <= key_in;
         midx_ff   <= midx_in;
      end
   end

endmodule

[hw/rtl/wsfr_out_reg.sv]
// Result register between the parser and the result channel.
module wsfr_out_reg
   import wsfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type res,
   input  logic       take,
   output logic       full,
   output result_type held
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign valid_in = load ? res.valid : (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign full = valid_ff;

   always_comb begin
      held       = data_ff;
      held.valid = valid_ff;
   end

endmodule

[hw/rtl/websocket_frame_receiver_core.sv]
// Top level of the WebSocket frame receiver.
// Takes one link byte per word on the req_ channel and deframes WebSocket
// frames: header, 16- or 64-bit extended length, optional masking key, then
// unmasked payload bytes on the rsp_ channel with tlast on the final byte.
// Kind (tuser) 1 is an empty message, 2 a close opcode or a link abort
// (req_tuser high). One word is accepted every clock unless the result word
// stalls; the parser state is updated in the cycle of acceptance and its result
// appears in the next cycle from a single result register, which is refilled in
// the same cycle it is drained: one word per cycle while rsp_tready stays high.
module websocket_frame_receiver_core
   import wsfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   input  logic                  req_tuser,   // [0] link_closed
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] payload_byte, [11:8] frame_opcode
   output logic [1:0]            rsp_tuser,   // [1:0] kind
   output logic                  rsp_tlast
);

   logic       step;
   logic       full;
   result_type res;
   result_type held;

   assign req_tready = !full || rsp_tready;
   assign step       = req_tvalid && req_tready;

   wsfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (req_tdata),
      .link_closed (req_tuser),
      .res         (res)
   );

   wsfr_out_reg u_out_reg (
      .clock (clock),
      .reset (reset),
      .load  (step),
      .res   (res),
      .take  (rsp_tready),
      .full  (full),
      .held  (held)
   );

   assign rsp_tvalid = held.valid;
   assign rsp_tdata  = {{(RSP_DATA_W-OPCODE_W-BYTE_W){1'b0}}, held.frame_opcode,
                        held.payload_byte};
   assign rsp_tuser  = held.kind;
   assign rsp_tlast  = held.last;

   a_abort_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=>
         rsp_tvalid && rsp_tuser == KIND_CLOSE && rsp_tlast && rsp_tdata == '0)
      else $error("link abort did not give a close word");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result word is stalled");

   a_nonbyte_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_BYTE |-> rsp_tlast && rsp_tdata[7:0] == '0)
      else $error("empty or close word without tlast or with data");

   a_no_kind3: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined result kind");

endmodule
